/* hdl/mdcd_pkg.sv */
package mdcd_pkg;

  // Number of button slots; valid button numbers run from 1 to BUTTONS-1.
  localparam int unsigned BUTTONS = 8;
  localparam int unsigned HELD_N  = BUTTONS - 1;
  localparam int unsigned IDX_W   = (HELD_N > 1) ? $clog2(HELD_N) : 1;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BTN_W   = 4;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned MOD_W   = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_BUTTON  = 2'd0,
    CMD_MOTION  = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    EV_MOVE   = 2'd0,
    EV_DOWN   = 2'd1,
    EV_UP     = 2'd2,
    EV_DOUBLE = 2'd3
  } ev_kind_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DC_TIME = 1'd0,
    CFG_DC_DIST = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOVE,
    ST_BTN,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic eval;
    logic emit_move;
    logic emit_btn;
    logic emit_up;
    logic scan_clear;
    logic scan_next;
    logic forget_click;
  } ctl_t;

  typedef struct packed {
    logic             in_valid;
    logic [CMD_W-1:0] cmd;
    logic             move_needed;
    logic             btn_go;
    logic             held_cur;
    logic             idx_last;
    logic             out_free;
  } stat_t;

endpackage

/* hdl/mdcd_if.sv */
interface mdcd_in_if;
  logic                                valid;
  logic                                ready;
  logic [mdcd_pkg::CMD_W-1:0]          command;
  logic [mdcd_pkg::BTN_W-1:0]          button_number;
  logic                                pressed;
  logic signed [mdcd_pkg::POS_W-1:0]   pos_x;
  logic signed [mdcd_pkg::POS_W-1:0]   pos_y;
  logic [mdcd_pkg::TS_W-1:0]           timestamp;
  logic [mdcd_pkg::MOD_W-1:0]          modifiers;

  modport source (output valid, command, button_number, pressed, pos_x, pos_y,
                  timestamp, modifiers, input ready);
  modport sink (input valid, command, button_number, pressed, pos_x, pos_y,
                timestamp, modifiers, output ready);
endinterface

interface mdcd_out_if;
  logic                                valid;
  logic                                ready;
  logic [mdcd_pkg::KIND_W-1:0]         event_kind;
  logic signed [mdcd_pkg::POS_W-1:0]   event_x;
  logic signed [mdcd_pkg::POS_W-1:0]   event_y;
  logic [mdcd_pkg::BTN_W-1:0]          event_button;
  logic [mdcd_pkg::MOD_W-1:0]          event_modifiers;
  logic                                last_of_run;

  modport source (output valid, event_kind, event_x, event_y, event_button,
                  event_modifiers, last_of_run, input ready);
  modport sink (input valid, event_kind, event_x, event_y, event_button,
                event_modifiers, last_of_run, output ready);
endinterface

interface mdcd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mdcd_pkg::CIDX_W-1:0]         index;
  logic [mdcd_pkg::CFG_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/mdcd_ctrl.sv */
module mdcd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mdcd_pkg::stat_t st_i,
  output mdcd_pkg::ctl_t  ctl_o
);
  import mdcd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.in_ready = 1'b1;
        if (st_i.in_valid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ctl_o.eval = 1'b1;
        unique case (st_i.cmd)
          CMD_BUTTON, CMD_MOTION: state_d = ST_MOVE;
          CMD_RELEASE: begin
            ctl_o.scan_clear = 1'b1;
            state_d          = ST_SCAN;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_MOVE: begin
        if (!st_i.move_needed || st_i.out_free) begin
          ctl_o.emit_move = st_i.move_needed;
          state_d         = st_i.btn_go ? ST_BTN : ST_IDLE;
        end
      end
      ST_BTN: begin
        if (st_i.out_free) begin
          ctl_o.emit_btn = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // A held button must wait for room in the output register.
        if (!st_i.held_cur || st_i.out_free) begin
          ctl_o.emit_up = st_i.held_cur;
          if (st_i.idx_last) begin
            ctl_o.forget_click = 1'b1;
            state_d            = ST_IDLE;
          end else begin
            ctl_o.scan_next = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hdl/mdcd_datapath.sv */
module mdcd_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  mdcd_in_if.sink         in_ch,
  mdcd_out_if.source      out_ch,
  mdcd_cfg_if.sink        cfg_ch,
  input  mdcd_pkg::ctl_t  ctl_i,
  output mdcd_pkg::stat_t st_o
);
  import mdcd_pkg::*;

  // Latched input item.
  logic [CMD_W-1:0]        cmd_q;
  logic [BTN_W-1:0]        btn_q;
  logic                    down_q;
  logic signed [POS_W-1:0] x_q, y_q;
  logic [TS_W-1:0]         ts_q;
  logic [MOD_W-1:0]        mods_q;

  logic [CFG_W-1:0]        dct_q, dcd_q;

  logic signed [POS_W-1:0] ptr_x_q, ptr_y_q;
  logic [HELD_N-1:0]       held_q;
  logic [BTN_W-1:0]        clk_btn_q;
  logic [TS_W-1:0]         clk_time_q;
  logic signed [POS_W-1:0] clk_x_q, clk_y_q;

  logic move_q, valid_btn_q, dbl_q;
  logic [IDX_W-1:0] idx_q;

  logic                    out_valid_q;
  logic [KIND_W-1:0]       out_kind_q;
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic [BTN_W-1:0]        out_btn_q;
  logic [MOD_W-1:0]        out_mods_q;
  logic                    out_last_q;

  logic                  load_in;
  logic                  out_free;
  logic                  move_w, valid_btn_w, dbl_w, in_time;
  logic [TS_W-1:0]       dt;
  logic signed [POS_W:0] dx, dy;
  logic signed [POS_W+1:0] dist_p, dist_n;
  logic                  near_x, near_y;
  logic [IDX_W-1:0]      bidx;
  logic                  higher_held;
  logic                  btn_go;

  assign in_ch.ready  = ctl_i.in_ready;
  assign load_in      = in_ch.valid && ctl_i.in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_q || out_ch.ready;

  // Evaluation of the latched report against stored state.
  assign move_w      = (x_q != ptr_x_q) || (y_q != ptr_y_q);
  assign valid_btn_w = (btn_q != '0) && ({1'b0, btn_q} < (BTN_W + 1)'(BUTTONS));
  assign dt          = ts_q - clk_time_q;
  assign in_time     = dt[TS_W-1] || (dt <= {{(TS_W - CFG_W){1'b0}}, dct_q});
  assign dx          = {x_q[POS_W-1], x_q} - {clk_x_q[POS_W-1], clk_x_q};
  assign dy          = {y_q[POS_W-1], y_q} - {clk_y_q[POS_W-1], clk_y_q};
  assign dist_p      = $signed({2'b00, dcd_q});
  assign dist_n      = -dist_p;
  assign near_x      = ($signed({dx[POS_W], dx}) <= dist_p) &&
                       ($signed({dx[POS_W], dx}) >= dist_n);
  assign near_y      = ($signed({dy[POS_W], dy}) <= dist_p) &&
                       ($signed({dy[POS_W], dy}) >= dist_n);
  assign dbl_w       = (btn_q == clk_btn_q) && in_time && near_x && near_y;

  assign bidx   = IDX_W'(btn_q - BTN_W'(1));
  assign btn_go = (cmd_q == CMD_BUTTON) && valid_btn_q;

  always_comb begin
    higher_held = 1'b0;
    for (int j = 0; j < int'(HELD_N); j++) begin
      if (held_q[j] && (j > int'(idx_q))) begin
        higher_held = 1'b1;
      end
    end
  end

  always_comb begin
    st_o             = '0;
    st_o.in_valid    = in_ch.valid;
    st_o.cmd         = cmd_q;
    st_o.move_needed = move_q;
    st_o.btn_go      = btn_go;
    st_o.held_cur    = held_q[idx_q];
    st_o.idx_last    = (idx_q == IDX_W'(HELD_N - 1));
    st_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      cmd_q  <= in_ch.command;
      btn_q  <= in_ch.button_number;
      down_q <= in_ch.pressed;
      x_q    <= in_ch.pos_x;
      y_q    <= in_ch.pos_y;
      ts_q   <= in_ch.timestamp;
      mods_q <= in_ch.modifiers;
    end
    if (ctl_i.eval) begin
      move_q      <= move_w;
      valid_btn_q <= valid_btn_w;
      dbl_q       <= dbl_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dct_q      <= '0;
      dcd_q      <= '0;
      ptr_x_q    <= '0;
      ptr_y_q    <= '0;
      held_q     <= '0;
      clk_btn_q  <= '0;
      clk_time_q <= '0;
      clk_x_q    <= '0;
      clk_y_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_DC_TIME: dct_q <= cfg_ch.data;
          CFG_DC_DIST: dcd_q <= cfg_ch.data;
          default: ;
        endcase
      end
      if (ctl_i.emit_move) begin
        ptr_x_q <= x_q;
        ptr_y_q <= y_q;
      end
      for (int j = 0; j < int'(HELD_N); j++) begin
        if (ctl_i.emit_btn && (int'(bidx) == j)) begin
          held_q[j] <= down_q;
        end else if (ctl_i.emit_up && (int'(idx_q) == j)) begin
          held_q[j] <= 1'b0;
        end
      end
      if (ctl_i.emit_btn && down_q) begin
        clk_btn_q  <= btn_q;
        clk_time_q <= ts_q;
        clk_x_q    <= x_q;
        clk_y_q    <= y_q;
      end else if (ctl_i.forget_click) begin
        clk_btn_q <= '0;
      end
      if (ctl_i.scan_clear) begin
        idx_q <= '0;
      end else if (ctl_i.scan_next) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // Output register: holds one event until the sink takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit_move || ctl_i.emit_btn || ctl_i.emit_up) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_move) begin
      out_kind_q <= EV_MOVE;
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_btn_q  <= '0;
      out_mods_q <= mods_q;
      out_last_q <= !btn_go;
    end else if (ctl_i.emit_btn) begin
      out_kind_q <= !down_q ? EV_UP : (dbl_q ? EV_DOUBLE : EV_DOWN);
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_btn_q  <= btn_q;
      out_mods_q <= mods_q;
      out_last_q <= 1'b1;
    end else if (ctl_i.emit_up) begin
      out_kind_q <= EV_UP;
      out_x_q    <= ptr_x_q;
      out_y_q    <= ptr_y_q;
      out_btn_q  <= BTN_W'(idx_q) + BTN_W'(1);
      out_mods_q <= mods_q;
      out_last_q <= !higher_held;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.event_kind      = out_kind_q;
  assign out_ch.event_x         = out_x_q;
  assign out_ch.event_y         = out_y_q;
  assign out_ch.event_button    = out_btn_q;
  assign out_ch.event_modifiers = out_mods_q;
  assign out_ch.last_of_run     = out_last_q;

endmodule

/* hdl/mouse_double_click_detector_top.sv */
// Pointer event generator with double-click detection.
// Input channel in_ch takes one pointer report per beat: a button report, a
// motion report or a release-all command. Output channel out_ch gives the
// resulting events, one per beat, with last_of_run set on the final event of
// each report. Channel cfg_ch writes the double-click time and distance
// limits; it is always ready and should only be used while the block is idle.
// A report is taken in the idle state and evaluated in the next cycle. A
// motion report then passes through the move state; a button report through
// the move state and then, for a valid button, the button state; release-all
// through the scan state, where the scan counter walks the held-button flags
// one per cycle unless a held button waits for the output register. Commands
// that are not defined return to idle after evaluation and give no events.
// The output register decouples the sink: a new report is accepted while the
// last event still waits; when the sink stalls, the controller holds until
// the output register is free. Reset clears the pointer position, held
// buttons, click memory and the configured limits.
module mouse_double_click_detector_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mdcd_in_if.sink    in_ch,
  mdcd_out_if.source out_ch,
  mdcd_cfg_if.sink   cfg_ch
);
  import mdcd_pkg::*;

  ctl_t  ctl;
  stat_t st;

  mdcd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .ctl_o  (ctl)
  );

  mdcd_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .ctl_i  (ctl),
    .st_o   (st)
  );

endmodule

/* tb/sv/mdcd_event_checker.sv */
`timescale 1ns / 1ps
module mdcd_event_checker
  import mdcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mdcd_in_if   in_ch,
  mdcd_out_if  out_ch,
  mdcd_cfg_if  cfg_ch,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    ev_kind_e           kind;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [BTN_W-1:0]   button;
    logic [MOD_W-1:0]   mods;
    logic               last;
  } ptr_event_t;

  logic [CFG_W-1:0]        dc_time;
  logic [CFG_W-1:0]        dc_dist;
  logic signed [POS_W-1:0] ptr_x;
  logic signed [POS_W-1:0] ptr_y;
  logic [HELD_N-1:0]       held;
  logic [BTN_W-1:0]        click_btn;
  logic [TS_W-1:0]         click_ts;
  logic signed [POS_W-1:0] click_x;
  logic signed [POS_W-1:0] click_y;

  ptr_event_t events_q[$];
  int         run_len;
  int         mismatches;

  function automatic void add_event(ev_kind_e kind, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                    logic [BTN_W-1:0] btn, logic [MOD_W-1:0] mods);
    ptr_event_t ev;
    ev.kind   = kind;
    ev.x      = x;
    ev.y      = y;
    ev.button = btn;
    ev.mods   = mods;
    ev.last   = 1'b0;
    events_q.push_back(ev);
    run_len++;
  endfunction

  function automatic void track_motion(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                       logic [MOD_W-1:0] mods);
    if (x != ptr_x || y != ptr_y) begin
      ptr_x = x;
      ptr_y = y;
      add_event(EV_MOVE, x, y, '0, mods);
    end
  endfunction

  function automatic void predict_report();
    logic [TS_W-1:0] dt;
    int              dx;
    int              dy;
    ev_kind_e        kind;
    ptr_event_t      tail;
    run_len = 0;
    case (in_ch.command)
      CMD_MOTION: track_motion(in_ch.pos_x, in_ch.pos_y, in_ch.modifiers);
      CMD_BUTTON: begin
        track_motion(in_ch.pos_x, in_ch.pos_y, in_ch.modifiers);
        if (in_ch.button_number != '0 && in_ch.button_number < BUTTONS) begin
          held[in_ch.button_number - 1] = in_ch.pressed;
          kind = in_ch.pressed ? EV_DOWN : EV_UP;
          if (in_ch.pressed) begin
            // A press earlier than the stored one (negative wrapped gap) still counts as in time.
            dt = in_ch.timestamp - click_ts;
            dx = int'(in_ch.pos_x) - int'(click_x);
            dy = int'(in_ch.pos_y) - int'(click_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (in_ch.button_number == click_btn && (dt[TS_W-1] || dt <= dc_time)
                && dx <= int'(dc_dist) && dy <= int'(dc_dist))
              kind = EV_DOUBLE;
            click_btn = in_ch.button_number;
            click_ts  = in_ch.timestamp;
            click_x   = in_ch.pos_x;
            click_y   = in_ch.pos_y;
          end
          add_event(kind, in_ch.pos_x, in_ch.pos_y, in_ch.button_number, in_ch.modifiers);
        end
      end
      CMD_RELEASE: begin
        for (int b = 0; b < HELD_N; b++) begin
          if (held[b]) begin
            held[b] = 1'b0;
            add_event(EV_UP, ptr_x, ptr_y, BTN_W'(b + 1), in_ch.modifiers);
          end
        end
        click_btn = '0;
      end
      default: ;
    endcase
    if (run_len > 0) begin
      tail = events_q.pop_back();
      tail.last = 1'b1;
      events_q.push_back(tail);
    end
  endfunction

  function automatic void check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: event %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ptr_event_t want;
    if (!rst_ni) begin
      dc_time      = '0;
      dc_dist      = '0;
      ptr_x        = '0;
      ptr_y        = '0;
      held         = '0;
      click_btn    = '0;
      click_ts     = '0;
      click_x      = '0;
      click_y      = '0;
      mismatches   = 0;
      events_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare first: an event leaving at this edge never belongs to a report taken at it.
      if (out_ch.valid && out_ch.ready) begin
        if (events_q.size() == 0) begin
          $display("%0t: event not expected, expected none, got kind %0d x %h y %h button %0d",
                   $time, out_ch.event_kind, out_ch.event_x, out_ch.event_y,
                   out_ch.event_button);
          mismatches++;
        end else begin
          want = events_q.pop_front();
          check_field("kind", want.kind, out_ch.event_kind);
          check_field("x", want.x, out_ch.event_x);
          check_field("y", want.y, out_ch.event_y);
          check_field("button", want.button, out_ch.event_button);
          check_field("modifiers", want.mods, out_ch.event_modifiers);
          check_field("last_of_run", want.last, out_ch.last_of_run);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_DC_TIME: dc_time = cfg_ch.data;
          CFG_DC_DIST: dc_dist = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_report();
      fail_count_o <= mismatches;
      pending_o    <= events_q.size();
    end
  end

endmodule

/* tb/sv/tb_mouse_double_click_detector_top.sv */
`timescale 1ns / 1ps
module tb_mouse_double_click_detector_top;
  import mdcd_pkg::*;

  localparam logic [CMD_W-1:0]        CMD_UNUSED   = 2'd3;
  localparam logic signed [POS_W-1:0] POS_MAX      = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] POS_MIN      = 16'sh8000;
  localparam int                      DRAIN_CYCLES = 20;
  localparam int                      HOLD_CYCLES  = 300;
  localparam int                      CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   items_sent;
  logic pressure_on;
  logic no_gaps;

  logic [CFG_W-1:0]        lim_time;
  logic [CFG_W-1:0]        lim_dist;
  logic signed [POS_W-1:0] cur_x;
  logic signed [POS_W-1:0] cur_y;
  logic [TS_W-1:0]         cur_ts;

  mdcd_in_if  in_ch();
  mdcd_out_if out_ch();
  mdcd_cfg_if cfg_ch();

  mouse_double_click_detector_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mdcd_event_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Event sink: random stalls, calm stretches, and one long hold-off under pressure.
  initial begin
    int   stall_left;
    int   mode_left;
    int   r;
    logic steady;
    logic squeezed;
    stall_left = 0;
    mode_left  = 0;
    steady     = 1'b0;
    squeezed   = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pressure_on && !squeezed) begin
        squeezed   = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 200);
      end
      mode_left--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Leaves valid high after the beat; the next call or a drain decides what follows.
  task automatic send_report(logic [CMD_W-1:0] cmd, logic [BTN_W-1:0] btn, logic pressed,
                             logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                             logic [TS_W-1:0] ts, logic [MOD_W-1:0] mods);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.button_number <= btn;
    in_ch.pressed       <= pressed;
    in_ch.pos_x         <= x;
    in_ch.pos_y         <= y;
    in_ch.timestamp     <= ts;
    in_ch.modifiers     <= mods;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    cur_ts = ts;
    if (cmd == CMD_BUTTON || cmd == CMD_MOTION) begin
      cur_x = x;
      cur_y = y;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Reports without events may still be in flight, a release-all scan the longest.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_DC_TIME) lim_time = val;
    else lim_dist = val;
  endtask

  task automatic set_limits(logic [CFG_W-1:0] t, logic [CFG_W-1:0] d, logic wr_t, logic wr_d);
    drain();
    if (wr_t) write_reg(CFG_DC_TIME, t);
    if (wr_d) write_reg(CFG_DC_DIST, d);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly presses and moves near the last reported position, so double clicks really happen.
  task automatic random_report();
    int                      r;
    int                      j;
    int                      p;
    logic [CMD_W-1:0]        cmd;
    logic [BTN_W-1:0]        btn;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [TS_W-1:0]         ts;
    j = (lim_dist > 200) ? 200 : int'(lim_dist) + 1;
    r = $urandom_range(0, 99);
    if (r < 55) cmd = CMD_BUTTON;
    else if (r < 80) cmd = CMD_MOTION;
    else if (r < 93) cmd = CMD_RELEASE;
    else cmd = CMD_UNUSED;
    p = $urandom_range(0, 9);
    x = cur_x;
    y = cur_y;
    if (p == 9) begin
      x = POS_W'($urandom());
      y = POS_W'($urandom());
    end else if (p >= 5) begin
      x = POS_W'(int'(cur_x) + $urandom_range(0, 2 * j) - j);
      y = POS_W'(int'(cur_y) + $urandom_range(0, 2 * j) - j);
    end
    p = $urandom_range(0, 9);
    if (p == 0) ts = $urandom();
    else if (p == 1) ts = cur_ts - $urandom_range(0, 100);
    else ts = cur_ts + $urandom_range(0, 2 * int'(lim_time) + 4);
    p = $urandom_range(0, 9);
    if (p < 6) btn = BTN_W'($urandom_range(1, 2));
    else if (p < 9) btn = BTN_W'($urandom_range(1, BUTTONS - 1));
    else btn = BTN_W'($urandom_range(0, 15));
    send_report(cmd, btn, ($urandom_range(0, 3) != 0), x, y, ts, MOD_W'($urandom_range(0, 7)));
  endtask

  task automatic run_random(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) random_report();
  endtask

  initial begin
    rst_n       = 1'b0;
    items_sent  = 0;
    pressure_on <= 1'b0;
    no_gaps     = 1'b0;
    lim_time    = '0;
    lim_dist    = '0;
    cur_x       = '0;
    cur_y       = '0;
    cur_ts      = '0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_MOTION;
    in_ch.button_number <= '0;
    in_ch.pressed       <= 1'b0;
    in_ch.pos_x         <= '0;
    in_ch.pos_y         <= '0;
    in_ch.timestamp     <= '0;
    in_ch.modifiers     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_DC_TIME;
    cfg_ch.data         <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_limits(16'd50, 16'd4, 1'b1, 1'b1);
    send_report(CMD_MOTION, 4'd0, 1'b0, 16'sd0, 16'sd0, 32'd0, 3'd0);
    send_report(CMD_MOTION, 4'd0, 1'b0, POS_MAX, POS_MIN, 32'd10, 3'd1);
    send_report(CMD_BUTTON, 4'd1, 1'b1, POS_MAX, POS_MIN, 32'd1000, 3'd2);
    send_report(CMD_BUTTON, 4'd1, 1'b0, POS_MAX, POS_MIN, 32'd1010, 3'd3);
    // Move by exactly the distance limit, then presses at and just past the time limit.
    send_report(CMD_BUTTON, 4'd1, 1'b1, POS_MAX - 16'sd4, POS_MIN + 16'sd4, 32'd1040, 3'd4);
    send_report(CMD_BUTTON, 4'd1, 1'b1, POS_MAX - 16'sd4, POS_MIN + 16'sd4, 32'd1091, 3'd5);
    send_report(CMD_BUTTON, 4'd1, 1'b1, POS_MAX - 16'sd4, POS_MIN + 16'sd4, 32'd1141, 3'd6);
    send_report(CMD_BUTTON, 4'd2, 1'b1, POS_MAX - 16'sd4, POS_MIN + 16'sd4, 32'd1150, 3'd7);
    // Earlier timestamps count as in time; the first of these is one step too far away.
    send_report(CMD_BUTTON, 4'd2, 1'b1, POS_MAX - 16'sd9, POS_MIN + 16'sd4, 32'd1100, 3'd0);
    send_report(CMD_BUTTON, 4'd2, 1'b1, POS_MAX - 16'sd9, POS_MIN + 16'sd4, 32'd1060, 3'd1);
    send_report(CMD_BUTTON, 4'd0, 1'b1, 16'sd100, -16'sd100, 32'd1200, 3'd1);
    send_report(CMD_BUTTON, BTN_W'(BUTTONS), 1'b1, 16'sd100, -16'sd100, 32'd1210, 3'd2);
    send_report(CMD_BUTTON, 4'd15, 1'b0, 16'sd0, 16'sd0, 32'd1220, 3'd3);
    for (int b = 3; b < BUTTONS; b++)
      send_report(CMD_BUTTON, BTN_W'(b), 1'b1, 16'sd0, 16'sd0, 32'd1300 + b, MOD_W'(b));
    send_report(CMD_RELEASE, 4'd0, 1'b0, POS_MIN, POS_MAX, 32'd0, 3'd7);
    send_report(CMD_RELEASE, 4'd0, 1'b0, POS_MIN, POS_MAX, 32'd0, 3'd6);
    send_report(CMD_BUTTON, 4'd3, 1'b0, 16'sd0, 16'sd0, 32'd1400, 3'd5);
    send_report(CMD_UNUSED, 4'd5, 1'b1, 16'sd1, 16'sd1, 32'd1, 3'd6);
    send_report(CMD_BUTTON, 4'd1, 1'b1, 16'sd0, 16'sd0, 32'hFFFF_FFF0, 3'd0);
    send_report(CMD_BUTTON, 4'd1, 1'b1, 16'sd0, 16'sd0, 32'h0000_0010, 3'd7);
    send_report(CMD_BUTTON, BTN_W'(BUTTONS - 1), 1'b0, POS_MIN, POS_MAX, 32'hFFFF_FFFF, 3'd7);

    set_limits(16'd0, 16'd0, 1'b1, 1'b1);
    run_random(25);

    set_limits(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    no_gaps = 1'b1;
    run_random(12);
    no_gaps = 1'b0;
    run_random(13);

    // The sink holds off while every button goes down and is released at once.
    set_limits(CFG_W'($urandom_range(1, 300)), '0, 1'b1, 1'b0);
    pressure_on <= 1'b1;
    no_gaps = 1'b1;
    for (int b = 1; b < BUTTONS; b++)
      send_report(CMD_BUTTON, BTN_W'(b), 1'b1, POS_W'($urandom()), POS_W'($urandom()),
                  $urandom(), MOD_W'($urandom_range(0, 7)));
    send_report(CMD_RELEASE, 4'd0, 1'b0, cur_x, cur_y, cur_ts, MOD_W'($urandom_range(0, 7)));
    run_random(10);
    no_gaps = 1'b0;
    pressure_on <= 1'b0;

    set_limits('0, CFG_W'($urandom_range(1, 50)), 1'b0, 1'b1);
    run_random(10);

    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/mdcd_pkg.sv
hdl/mdcd_if.sv
hdl/mdcd_ctrl.sv
hdl/mdcd_datapath.sv
hdl/mouse_double_click_detector_top.sv
tb/sv/mdcd_event_checker.sv
tb/sv/tb_mouse_double_click_detector_top.sv
